// ----- design/scsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Size-class slot allocator package
// Request/response types, decoded queue item, status codes and helpers.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int GROUP_COUNT     = 13;
  localparam int POOLS_PER_GROUP = 16;
  localparam int SLOTS_PER_POOL  = 32;
  localparam int AVAIL_DEPTH     = 32;
  localparam int SMALLEST_SHIFT  = 7;
  localparam int HEADER_BYTES    = 16;

  localparam logic [2:0] ST_IN_PLACE  = 3'd0;
  localparam logic [2:0] ST_ALLOC     = 3'd1;
  localparam logic [2:0] ST_MOVED     = 3'd2;
  localparam logic [2:0] ST_FREED     = 3'd3;
  localparam logic [2:0] ST_NULL_FREE = 3'd4;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd5;
  localparam logic [2:0] ST_NO_POOLS  = 3'd6;
  localparam logic [2:0] ST_BAD_FREE  = 3'd7;

  typedef struct packed {
    logic        kind;
    logic        has_old;
    logic [3:0]  old_group;
    logic [3:0]  old_pool;
    logic [4:0]  old_slot;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  new_group;
    logic [3:0]  new_pool;
    logic [4:0]  new_slot;
    logic [30:0] new_capacity;
    logic [30:0] copy_length;
  } rsp_t;

  // Request after classification by the front end
  typedef struct packed {
    req_t       req;
    logic [3:0] grp;
    logic       zero_amt;
    logic       bad_grp;
    logic       fits;
  } item_t;

  function automatic logic [30:0] cap_of(input logic [3:0] g);
    logic [31:0] sz;
    sz = 32'd1 << (5'(g) * 5'd2 + 5'(SMALLEST_SHIFT));
    return 31'(sz - 32'(HEADER_BYTES));
  endfunction

endpackage

// ----- design/scsa_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, works out the size group and the in-place fit, queues.
// ----------------------------------------------------------------------------
module scsa_front (
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  scsa_pkg::req_t  in_data,
  input  logic            q_full,
  output logic            q_push,
  output scsa_pkg::item_t q_item
);
  import scsa_pkg::*;

  logic [32:0] total;
  logic [5:0]  msb;
  logic [5:0]  sbits;
  logic [5:0]  g6;
  logic        seen;

  always_comb begin
    total = 33'(in_data.amount) + 33'(HEADER_BYTES);
    msb   = '0;
    seen  = 1'b0;
    for (int i = 32; i >= 0; i--) begin
      if (!seen && total[i]) begin
        msb  = 6'(i);
        seen = 1'b1;
      end
    end
    sbits = msb + 6'd2;
    g6    = (sbits >= 6'(SMALLEST_SHIFT)) ? ((sbits - 6'(SMALLEST_SHIFT)) >> 1) : 6'd0;
  end

  assign in_ready = !q_full && !rst;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.req      = in_data;
    q_item.grp      = g6[3:0];
    q_item.zero_amt = (in_data.amount == 32'd0);
    q_item.bad_grp  = (g6 >= 6'(GROUP_COUNT));
    q_item.fits     = (in_data.old_group < 4'(GROUP_COUNT)) &&
                      ({1'b0, cap_of(in_data.old_group)} >= in_data.amount);
  end

endmodule

// ----- design/scsa_queue.sv -----
// ----------------------------------------------------------------------------
// Request queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module scsa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scsa_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output scsa_pkg::item_t head
);
  import scsa_pkg::*;

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- design/scsa_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Sequencer over the pool and vacancy stacks; holds one response register.
// ----------------------------------------------------------------------------
module scsa_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  scsa_pkg::item_t q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output scsa_pkg::rsp_t  out_data
);
  import scsa_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHK       = 4'd1;
  localparam logic [3:0] S_OLD       = 4'd2;
  localparam logic [3:0] S_ALLOC_A   = 4'd3;
  localparam logic [3:0] S_ALLOC_B   = 4'd4;
  localparam logic [3:0] S_ALLOC_C   = 4'd5;
  localparam logic [3:0] S_ALLOC_D   = 4'd6;
  localparam logic [3:0] S_CLAIM     = 4'd7;
  localparam logic [3:0] S_FILL      = 4'd8;
  localparam logic [3:0] S_CLAIM_END = 4'd9;
  localparam logic [3:0] S_WNEW      = 4'd10;
  localparam logic [3:0] S_FREE_A    = 4'd11;
  localparam logic [3:0] S_FREE_B    = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0] state;
  item_t      it;

  logic [4:0] pools_claimed [16];
  logic [5:0] avail_count   [16];

  logic [3:0]  avail_mem [512];
  logic [5:0]  vcount_mem [256];
  logic [4:0]  vstack_mem [8192];
  logic [30:0] used_mem  [8192];

  logic [3:0]  av_rd;
  logic [5:0]  vc_rd;
  logic [4:0]  vs_rd;
  logic [30:0] used_rd;

  logic [8:0]  av_ra, av_wa;
  logic [7:0]  vc_ra, vc_wa;
  logic [12:0] vs_ra, vs_wa, used_ra, used_wa;
  logic        av_we, vc_we, vs_we, used_we;
  logic [3:0]  av_wd;
  logic [5:0]  vc_wd;
  logic [4:0]  vs_wd;
  logic [30:0] used_wd;

  logic [3:0]  p_r;
  logic [4:0]  s_r;
  logic [4:0]  fill_i;
  logic [30:0] old_used;
  rsp_t        res;

  logic [3:0] g, og, op;
  logic [4:0] os;
  logic [5:0] ac_g, ac_og;

  assign g     = it.grp;
  assign og    = it.req.old_group;
  assign op    = it.req.old_pool;
  assign os    = it.req.old_slot;
  assign ac_g  = avail_count[g];
  assign ac_og = avail_count[og];
  assign q_pop = (state == S_IDLE) && q_not_empty;

  // Memory addresses and write ports
  always_comb begin
    av_ra   = {g, 5'(ac_g - 6'd1)};
    vc_ra   = (state == S_ALLOC_B) ? {g, av_rd} : {og, op};
    vs_ra   = {g, p_r, 5'(vc_rd - 6'd1)};
    used_ra = {og, op, os};
    av_we = 1'b0; av_wa = {g, ac_g[4:0]}; av_wd = p_r;
    vc_we = 1'b0; vc_wa = {g, p_r};       vc_wd = vc_rd - 6'd1;
    vs_we = 1'b0; vs_wa = {g, p_r, fill_i}; vs_wd = ~fill_i;
    used_we = 1'b0; used_wa = {og, op, os}; used_wd = '0;
    case (state)
      S_OLD: begin
        used_we = !it.req.kind && !it.zero_amt && it.req.has_old && it.fits &&
                  (used_rd != '0);
        used_wd = it.req.amount[30:0];
      end
      S_ALLOC_C: vc_we = (vc_rd != 6'd0);
      S_FILL: begin
        vs_we   = 1'b1;
        used_we = 1'b1;
        used_wa = {g, p_r, fill_i};
      end
      S_CLAIM_END: begin
        vc_we = 1'b1;
        vc_wd = 6'(SLOTS_PER_POOL - 1);
        av_we = (ac_g < 6'(AVAIL_DEPTH));
      end
      S_WNEW: begin
        used_we = 1'b1;
        used_wa = {g, p_r, s_r};
        used_wd = it.req.amount[30:0];
      end
      S_FREE_B: begin
        vs_we   = (vc_rd < 6'(SLOTS_PER_POOL));
        vs_wa   = {og, op, vc_rd[4:0]};
        vs_wd   = os;
        vc_we   = vs_we;
        vc_wa   = {og, op};
        vc_wd   = vc_rd + 6'd1;
        av_we   = vs_we && (vc_rd == 6'd0) && (ac_og < 6'(AVAIL_DEPTH));
        av_wa   = {og, ac_og[4:0]};
        av_wd   = op;
        used_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (av_we)   avail_mem[av_wa]   <= av_wd;
    if (vc_we)   vcount_mem[vc_wa]  <= vc_wd;
    if (vs_we)   vstack_mem[vs_wa]  <= vs_wd;
    if (used_we) used_mem[used_wa]  <= used_wd;
    av_rd   <= avail_mem[av_ra];
    vc_rd   <= vcount_mem[vc_ra];
    vs_rd   <= vstack_mem[vs_ra];
    used_rd <= used_mem[used_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        pools_claimed[i] <= '0;
        avail_count[i]   <= '0;
      end
    end else begin
      // drop the response once taken, unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            it    <= q_head;
            res   <= '0;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (it.req.has_old && ((og >= 4'(GROUP_COUNT)) ||
              (5'(op) >= pools_claimed[og]))) begin
            res.status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else if (!it.req.has_old && it.req.kind) begin
            res.status <= ST_NULL_FREE;
            state      <= S_DONE;
          end else begin
            state <= S_OLD;
          end
        end
        S_OLD: begin
          old_used <= used_rd;
          if (it.req.has_old && used_rd == '0) begin
            res.status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else if (it.req.kind) begin
            res.status <= ST_FREED;
            state      <= S_FREE_A;
          end else if (it.zero_amt) begin
            res.status <= ST_BAD_SIZE;
            state      <= S_DONE;
          end else if (it.req.has_old && it.fits) begin
            res.status       <= ST_IN_PLACE;
            res.new_group    <= og;
            res.new_pool     <= op;
            res.new_slot     <= os;
            res.new_capacity <= cap_of(og);
            state            <= S_DONE;
          end else if (it.bad_grp) begin
            res.status <= ST_BAD_SIZE;
            state      <= S_DONE;
          end else begin
            state <= S_ALLOC_A;
          end
        end
        S_ALLOC_A: state <= (ac_g != 6'd0) ? S_ALLOC_B : S_CLAIM;
        S_ALLOC_B: begin
          p_r   <= av_rd;
          state <= S_ALLOC_C;
        end
        S_ALLOC_C: begin
          if (vc_rd != 6'd0) begin
            if (vc_rd == 6'd1) avail_count[g] <= ac_g - 6'd1;
            state <= S_ALLOC_D;
          end else begin
            // stale entry: drop it and claim a fresh pool
            avail_count[g] <= ac_g - 6'd1;
            state          <= S_CLAIM;
          end
        end
        S_ALLOC_D: begin
          s_r   <= vs_rd;
          state <= S_WNEW;
        end
        S_CLAIM: begin
          if (pools_claimed[g] >= 5'(POOLS_PER_GROUP)) begin
            res.status <= ST_NO_POOLS;
            state      <= S_DONE;
          end else begin
            p_r              <= pools_claimed[g][3:0];
            pools_claimed[g] <= pools_claimed[g] + 5'd1;
            fill_i           <= '0;
            state            <= S_FILL;
          end
        end
        S_FILL: begin
          fill_i <= fill_i + 5'd1;
          if (fill_i == 5'(SLOTS_PER_POOL - 1)) state <= S_CLAIM_END;
        end
        S_CLAIM_END: begin
          s_r <= '0;
          if (ac_g < 6'(AVAIL_DEPTH)) avail_count[g] <= ac_g + 6'd1;
          state <= S_WNEW;
        end
        S_WNEW: begin
          res.new_group    <= g;
          res.new_pool     <= p_r;
          res.new_slot     <= s_r;
          res.new_capacity <= cap_of(g);
          if (it.req.has_old) begin
            res.status      <= ST_MOVED;
            res.copy_length <= old_used;
            state           <= S_FREE_A;
          end else begin
            res.status <= ST_ALLOC;
            state      <= S_DONE;
          end
        end
        S_FREE_A: state <= S_FREE_B;
        S_FREE_B: begin
          if (vc_rd == 6'd0 && ac_og < 6'(AVAIL_DEPTH)) avail_count[og] <= ac_og + 6'd1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/size_class_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Size-class slot allocator
// Allocate, resize and free slots held in per-group pools and vacancy stacks.
// ----------------------------------------------------------------------------
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   in_data  (req_t)
//   out      out  out_valid / out_ready out_data (rsp_t)
//
// A response is ready once the chain of registered stack reads is through;
// a request that claims a fresh pool also fills the pool's vacancy stack.
// Reset is synchronous; no clearing pass is needed, as slot usage of a pool
// is cleared while the pool is claimed.
// A two-entry queue lets the front end accept while the back end or the
// response register is stalled.
module size_class_slot_allocator_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  scsa_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output scsa_pkg::rsp_t out_data
);
  import scsa_pkg::*;

  logic  q_push, q_full, q_pop, q_not_empty;
  item_t q_item, q_head;

  scsa_front u_front (
    .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_full(q_full), .q_push(q_push), .q_item(q_item)
  );

  scsa_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_item(q_item), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
  );

  scsa_back u_back (
    .clk(clk), .rst(rst), .q_not_empty(q_not_empty), .q_head(q_head),
    .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status >= ST_FREED) |->
      (out_data.new_capacity == '0) && (out_data.copy_length == '0))
    else $error("error status with non-zero fields");

  a_copy_only_moved: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_MOVED) |-> (out_data.copy_length == '0))
    else $error("copy length outside a move");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response valid after reset");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Size-class slot allocator testbench
// A table of directed requests runs first, then about 1300 random requests.
// Most random requests allocate, resize or free live slots; the rest are
// malformed. Every response is checked against a typed expectation or an
// in-bench allocator model. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import scsa_pkg::*;

  localparam int POOL_TOTAL = GROUP_COUNT * POOLS_PER_GROUP;
  localparam int SLOT_TOTAL = POOL_TOTAL * SLOTS_PER_POOL;
  localparam int RANDOM_REQS = 1300;
  localparam longint MASK31 = 64'h7FFF_FFFF;

  typedef struct {
    int unsigned g;
    int unsigned p;
    int unsigned s;
  } handle_t;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  int errors = 0;
  int long_hold = 0;
  rsp_t rsp_q[$];
  vector_t vectors[$];
  handle_t live_slots[$];

  // allocator state
  int unsigned pools_claimed[GROUP_COUNT] = '{default: 0};
  int unsigned avail_cnt[GROUP_COUNT] = '{default: 0};
  int unsigned avail_stk[GROUP_COUNT * AVAIL_DEPTH] = '{default: 0};
  int unsigned vac_cnt[POOL_TOTAL] = '{default: 0};
  int unsigned vac_stk[SLOT_TOTAL] = '{default: 0};
  int unsigned used_bytes[SLOT_TOTAL] = '{default: 0};

  size_class_slot_allocator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint capacity(int unsigned g);
    longint sz;
    sz = 64'd1 << (2 * g + SMALLEST_SHIFT);
    return (sz > HEADER_BYTES) ? sz - HEADER_BYTES : 0;
  endfunction

  function automatic int unsigned sat31(longint a);
    return (a > MASK31) ? int'(MASK31) : int'(a);
  endfunction

  function automatic void drop_live(int unsigned g, int unsigned p, int unsigned s);
    foreach (live_slots[i])
      if (live_slots[i].g == g && live_slots[i].p == p && live_slots[i].s == s) begin
        live_slots.delete(i);
        return;
      end
  endfunction

  function automatic void release_slot(int unsigned g, int unsigned p, int unsigned s);
    int unsigned pi;
    pi = g * POOLS_PER_GROUP + p;
    if (vac_cnt[pi] < SLOTS_PER_POOL) begin
      vac_stk[pi * SLOTS_PER_POOL + vac_cnt[pi]] = s;
      vac_cnt[pi]++;
      if (vac_cnt[pi] == 1 && avail_cnt[g] < AVAIL_DEPTH) begin
        avail_stk[g * AVAIL_DEPTH + avail_cnt[g]] = p;
        avail_cnt[g]++;
      end
    end
    used_bytes[pi * SLOTS_PER_POOL + s] = 0;
    drop_live(g, p, s);
  endfunction

  // Work out the response to one request and advance the allocator state
  function automatic rsp_t allocate_or_free(req_t r);
    rsp_t o;
    int unsigned og, op, os, old_si, old_used, g, p, s, pi, n;
    longint amt, x;
    bit got;
    handle_t h;
    o = '0;
    og = r.old_group; op = r.old_pool; os = r.old_slot;
    amt = longint'(r.amount);
    old_si = 0; old_used = 0; got = 0;
    if (r.has_old) begin
      if (og >= GROUP_COUNT || op >= pools_claimed[og] || os >= SLOTS_PER_POOL) begin
        o.status = ST_BAD_FREE;
        return o;
      end
      old_si = (og * POOLS_PER_GROUP + op) * SLOTS_PER_POOL + os;
      old_used = used_bytes[old_si];
      if (old_used == 0) begin
        o.status = ST_BAD_FREE;
        return o;
      end
    end
    if (r.kind) begin
      if (!r.has_old) begin
        o.status = ST_NULL_FREE;
        return o;
      end
      release_slot(og, op, os);
      o.status = ST_FREED;
      return o;
    end
    if (amt == 0) begin
      o.status = ST_BAD_SIZE;
      return o;
    end
    if (r.has_old && capacity(og) >= amt) begin
      used_bytes[old_si] = sat31(amt);
      o.status = ST_IN_PLACE;
      o.new_group = 4'(og); o.new_pool = 4'(op); o.new_slot = 5'(os);
      o.new_capacity = 31'(capacity(og));
      return o;
    end
    x = amt + HEADER_BYTES;
    n = 0;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    n = n + 2;
    g = (n >= SMALLEST_SHIFT) ? (n - SMALLEST_SHIFT) >> 1 : 0;
    if (g >= GROUP_COUNT) begin
      o.status = ST_BAD_SIZE;
      return o;
    end
    p = 0; s = 0;
    if (avail_cnt[g] > 0) begin
      p = avail_stk[g * AVAIL_DEPTH + avail_cnt[g] - 1];
      if (p < POOLS_PER_GROUP && vac_cnt[g * POOLS_PER_GROUP + p] > 0) begin
        pi = g * POOLS_PER_GROUP + p;
        vac_cnt[pi]--;
        s = vac_stk[pi * SLOTS_PER_POOL + vac_cnt[pi]] % SLOTS_PER_POOL;
        if (vac_cnt[pi] == 0) avail_cnt[g]--;
        got = 1;
      end else begin
        // stale pool on the stack: drop it and claim a fresh one
        avail_cnt[g]--;
      end
    end
    if (!got) begin
      if (pools_claimed[g] >= POOLS_PER_GROUP) begin
        o.status = ST_NO_POOLS;
        return o;
      end
      p = pools_claimed[g];
      pools_claimed[g]++;
      pi = g * POOLS_PER_GROUP + p;
      for (int i = 0; i < SLOTS_PER_POOL; i++)
        vac_stk[pi * SLOTS_PER_POOL + i] = SLOTS_PER_POOL - 1 - i;
      vac_cnt[pi] = SLOTS_PER_POOL - 1;
      s = 0;
      if (avail_cnt[g] < AVAIL_DEPTH) begin
        avail_stk[g * AVAIL_DEPTH + avail_cnt[g]] = p;
        avail_cnt[g]++;
      end
    end
    used_bytes[(g * POOLS_PER_GROUP + p) * SLOTS_PER_POOL + s] = sat31(amt);
    h.g = g; h.p = p; h.s = s;
    live_slots.push_back(h);
    o.new_group = 4'(g); o.new_pool = 4'(p); o.new_slot = 5'(s);
    o.new_capacity = 31'(capacity(g));
    if (r.has_old) begin
      release_slot(og, op, os);
      o.status = ST_MOVED;
      o.copy_length = 31'(old_used);
    end else begin
      o.status = ST_ALLOC;
    end
    return o;
  endfunction

  function automatic req_t mk(bit kind, bit has, int g, int p, int s, logic [31:0] amt);
    req_t r;
    r.kind = kind; r.has_old = has;
    r.old_group = 4'(g); r.old_pool = 4'(p); r.old_slot = 5'(s);
    r.amount = amt;
    return r;
  endfunction

  function automatic logic [31:0] random_amount(bit fill);
    int unsigned k, m;
    m = $urandom_range(0, 9);
    if (fill && m < 9) return $urandom_range(1, int'(capacity(0)));
    if (m == 9) return $urandom();
    k = (m < 7) ? $urandom_range(0, 4) : $urandom_range(0, 12);
    return $urandom_range(1, int'(capacity(k)));
  endfunction

  // Mostly well-formed traffic on live slots, with some malformed requests
  function automatic req_t random_request(bit fill);
    int unsigned r;
    handle_t h;
    r = $urandom_range(0, 99);
    if (fill) r = (r < 85) ? 0 : r;
    if (r < 40 || (r < 85 && live_slots.size() == 0))
      return mk(1'b0, 1'b0, 0, 0, 0, random_amount(fill));
    if (r < 85) begin
      h = live_slots[$urandom_range(0, live_slots.size() - 1)];
      if (r < 60) return mk(1'b0, 1'b1, h.g, h.p, h.s, random_amount(fill));
      return mk(1'b1, 1'b1, h.g, h.p, h.s, $urandom());
    end
    return mk($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15),
              $urandom_range(0, 15), $urandom_range(0, 31),
              ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom());
  endfunction

  task automatic report(string what, longint got, longint exp);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    errors++;
  endtask

  // Offer one request and hold it until accepted
  task automatic send(req_t r, bit typed, rsp_t typed_rsp, bit no_gaps);
    rsp_t p;
    int unsigned gap, m;
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    p = allocate_or_free(r);
    rsp_q.push_back(typed ? typed_rsp : p);
    m = $urandom_range(0, 99);
    gap = (no_gaps || m < 60) ? 0 : (m < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random short and long stalls, plus an extended hold on request
  initial begin
    int unsigned stall, m;
    stall = 0;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        m = $urandom_range(0, 199);
        if (m < 10) stall = $urandom_range(1, 3);
        else if (m == 10) stall = $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && out_valid && out_ready) begin
      if (rsp_q.size() == 0) begin
        report("unexpected response status", out_data.status, 0);
      end else begin
        e = rsp_q.pop_front();
        if (out_data.status != e.status) report("status", out_data.status, e.status);
        if (out_data.new_group != e.new_group)
          report("new_group", out_data.new_group, e.new_group);
        if (out_data.new_pool != e.new_pool)
          report("new_pool", out_data.new_pool, e.new_pool);
        if (out_data.new_slot != e.new_slot)
          report("new_slot", out_data.new_slot, e.new_slot);
        if (out_data.new_capacity != e.new_capacity)
          report("new_capacity", out_data.new_capacity, e.new_capacity);
        if (out_data.copy_length != e.copy_length)
          report("copy_length", out_data.copy_length, e.copy_length);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("size_class_slot_allocator_top regression: fail");
    $finish;
  end

  initial begin
    rsp_t none;
    bit quiet;
    none = '0;
    // directed table: typed expectations where they are plain, else the model
    vectors.push_back('{mk(1, 0, 0, 0, 0, 0), 1, '{ST_NULL_FREE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(0, 0, 0, 0, 0, 0), 1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(0, 0, 0, 0, 0, 32'd2147483632), 1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(0, 0, 0, 0, 0, 32'd2147483631), 1,
                        '{ST_ALLOC, 12, 0, 0, 31'd2147483632, 0}});
    vectors.push_back('{mk(0, 0, 0, 0, 0, 1), 1, '{ST_ALLOC, 0, 0, 0, 112, 0}});
    vectors.push_back('{mk(0, 1, 0, 0, 0, 100), 1, '{ST_IN_PLACE, 0, 0, 0, 112, 0}});
    vectors.push_back('{mk(0, 1, 0, 0, 0, 0), 1, '{ST_BAD_SIZE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(0, 1, 0, 0, 0, 500), 0, none});
    vectors.push_back('{mk(1, 1, 0, 0, 0, 0), 1, '{ST_BAD_FREE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(1, 1, 15, 15, 31, 0), 1, '{ST_BAD_FREE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(1, 1, 0, 5, 0, 0), 1, '{ST_BAD_FREE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(0, 1, 2, 0, 7, 64), 1, '{ST_BAD_FREE, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(1, 1, 2, 0, 0, 0), 1, '{ST_FREED, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(0, 1, 12, 0, 0, 32'hFFFF_FFFF), 0, none});
    vectors.push_back('{mk(0, 1, 12, 0, 0, 32'd2147483632), 0, none});
    vectors.push_back('{mk(0, 0, 0, 0, 0, 113), 0, none});
    vectors.push_back('{mk(0, 0, 0, 0, 0, 32'h5555_5555), 0, none});
    vectors.push_back('{mk(1, 1, 12, 0, 0, 0), 1, '{ST_FREED, 0, 0, 0, 0, 0}});
    vectors.push_back('{mk(1, 1, 12, 0, 0, 0), 1, '{ST_BAD_FREE, 0, 0, 0, 0, 0}});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (vectors[i]) send(vectors[i].req, vectors[i].typed, vectors[i].rsp, 1'b0);
    drain();

    quiet = 0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      // stretches with no sender gaps
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == 300) long_hold = 400;
      if (i == 700) drain();
      send(random_request(i < 650), 1'b0, none, quiet);
    end
    drain();
    repeat (60) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("size_class_slot_allocator_top regression: pass");
    end else begin
      $display("size_class_slot_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
